### rtl/sglfo_pkg.sv
// ----------------------------------------------------------------------------
// sglfo_pkg
// Shared types, widths, constants and the gain table for the stereo gain / LFO
// auto-pan block.
// ----------------------------------------------------------------------------
`default_nettype none

package sglfo_pkg;

  // Defaults for the top-level parameters
  localparam int DEFAULT_SINE_TABLE_DEPTH = 1024;
  localparam int DEFAULT_SAMPLE_BITS      = 24;

  // Configuration port
  localparam int CFG_DATA_W  = 21;
  localparam int CFG_INDEX_W = 2;
  localparam int CODE_W      = 7;
  localparam int STEP_W      = 21;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GAIN  = 2'd0,
    CFG_PAN   = 2'd1,
    CFG_STEP  = 2'd2,
    CFG_DEPTH = 2'd3
  } cfg_idx_t;

  // Fixed-point widths of the gain path
  localparam int GAIN_W   = 18;  // Q2.16 master gain, up to 2.0
  localparam int PAN_W    = 17;  // Q.16 pan weight, up to 1.0
  localparam int MG_W     = 18;  // Q2.16 gain times pan
  localparam int FACT_W   = 17;  // Q2.15 LFO factor, up to 2.0
  localparam int MULT_W   = 19;  // Q3.16 final multiplier
  localparam int SINE_W   = 16;  // Q1.15 sine magnitude, up to 1.0
  localparam int MAG_W    = 16;  // scaled LFO magnitude

  // Phase accumulator
  localparam int PHASE_W     = 32;
  localparam int PHASE_POS_W = 30;

  // Serial multiplier: multiplier operand width (covers every B operand)
  localparam int MUL_B_W = 19;

  // Serial divide by the depth denominator
  localparam int DIV_N_W        = 22;
  localparam int DIV_R_W        = 7;
  localparam int LFO_DEPTH_DEN  = 127;
  localparam int LFO_DEPTH_RND  = 63;

  localparam logic [PAN_W-1:0]  PAN_UNITY  = 17'd65536;
  localparam logic [CODE_W-1:0] PAN_CENTER = 7'd64;
  localparam logic [FACT_W-1:0] Q15_ONE    = 17'd32768;

  localparam logic [CODE_W-1:0] GAIN_RESET = 7'd90;
  localparam logic [CODE_W-1:0] PAN_RESET  = 7'd64;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MG_L,
    ST_MG_R,
    ST_IDX,
    ST_ROM,
    ST_MAG,
    ST_DIV,
    ST_ML,
    ST_MR,
    ST_OL,
    ST_OR,
    ST_DONE
  } sgl_state_t;

  // Square-law gain table: round(2 * g^2 / 127^2) in Q2.16
  typedef logic [GAIN_W-1:0] gain_tab_t [128];

  function automatic gain_tab_t build_gain_tab();
    gain_tab_t t;
    longint    v;
    for (int g = 0; g < 128; g++) begin
      v    = (longint'(g) * longint'(g) * 131072 + 8064) / 16129;
      t[g] = GAIN_W'(v);
    end
    return t;
  endfunction

  localparam gain_tab_t GAIN_TAB = build_gain_tab();

endpackage

`default_nettype wire

### rtl/stereo_gain_lfo_autopan.sv
// ----------------------------------------------------------------------------
// stereo_gain_lfo_autopan
// Stereo master gain, static pan and sine LFO auto-pan with saturation.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in      | input     | in_valid/in_stall  | in_left_sample, in_right_sample
//   out     | output    | out_valid/out_stall| out_left_out, out_right_out
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Every product goes through one shared bit-serial multiplier (19 multiplier
// bits per pass); the LFO adds two passes, a ROM read and a serial divide
// by 127. Reset is synchronous, clears the sequencer, the output valid flag
// and the phase, and loads the configuration registers with their defaults.
// A finished result waits in the output register while the next transaction
// is accepted; a result is only held back when the output is still full.
// A new item is accepted only once the last one has left the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_gain_lfo_autopan
  import sglfo_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = DEFAULT_SINE_TABLE_DEPTH,
  parameter int SAMPLE_BITS      = DEFAULT_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_left_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] in_right_sample,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_left_out,
  output logic signed [SAMPLE_BITS-1:0]      out_right_out,
  // configuration port
  input  wire logic                          cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int MUL_A_W = ((SAMPLE_BITS > PHASE_POS_W) ? SAMPLE_BITS : PHASE_POS_W) + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SAT_HI_W = MUL_P_W - 16 - SAMPLE_BITS + 1;

  // --------------------------------------------------------------------------
  // Quarter-wave sine ROM, Q1.15, built by a truncated Taylor series in Q30
  // --------------------------------------------------------------------------
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  typedef logic [SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH + 1];

  function automatic sine_rom_t build_sine();
    sine_rom_t          tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int k = 0; k < 8; k++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[k];
        if (k % 2 == 0) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > ONE_Q30) begin
        sum = ONE_Q30;
      end
      tab[i] = SINE_W'(($unsigned(sum) + 64'd16384) >> 15);
    end
    return tab;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  sgl_state_t state_r, state_nxt;
  logic       go_r;

  logic [CODE_W-1:0]  gain_code_r;
  logic [CODE_W-1:0]  pan_code_r;
  logic [STEP_W-1:0]  phase_step_r;
  logic [CODE_W-1:0]  depth_code_r;
  logic [PHASE_W-1:0] lfo_phase_r;

  logic signed [SAMPLE_BITS-1:0] samp_l_r;
  logic signed [SAMPLE_BITS-1:0] samp_r_r;
  logic [MG_W-1:0]    mg_l_r;
  logic [MG_W-1:0]    mg_r_r;
  logic [FACT_W-1:0]  f_l_r;
  logic [FACT_W-1:0]  f_r_r;
  logic [MULT_W-1:0]  ml_r;
  logic [MULT_W-1:0]  mr_r;
  logic [IDX_W-1:0]   rom_addr_r;
  logic [SINE_W-1:0]  rom_q_r;
  logic signed [SAMPLE_BITS-1:0] res_l_r;
  logic signed [SAMPLE_BITS-1:0] res_r_r;
  logic signed [SAMPLE_BITS-1:0] out_left_r;
  logic signed [SAMPLE_BITS-1:0] out_right_r;
  logic                          out_valid_r;

  logic                       lfo_en;
  logic                       in_accept;
  logic                       out_free;
  logic [GAIN_W-1:0]          gain_val;
  logic [PAN_W-1:0]           pan_l;
  logic [PAN_W-1:0]           pan_r;

  logic                        mul_start;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]          mul_b;
  logic                        mul_done;
  logic signed [MUL_P_W-1:0]   mul_prod;
  logic                        div_start;
  logic [DIV_N_W-1:0]          div_num;
  logic                        div_done;
  logic [MAG_W-1:0]            div_quot;

  logic [MUL_P_W-1:0]   rnd16;
  logic [MUL_P_W-1:0]   rnd15;
  logic [IDX_W-1:0]     idx_raw;
  logic [IDX_W-1:0]     idx_c;
  logic [IDX_W-1:0]     rom_addr;
  logic [SAT_HI_W-1:0]  sat_hi;
  logic signed [SAMPLE_BITS-1:0] sat_res;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_code_r  <= GAIN_RESET;
      pan_code_r   <= PAN_RESET;
      phase_step_r <= '0;
      depth_code_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GAIN:  gain_code_r  <= cfg_data[CODE_W-1:0];
        CFG_PAN:   pan_code_r   <= cfg_data[CODE_W-1:0];
        CFG_STEP:  phase_step_r <= cfg_data[STEP_W-1:0];
        CFG_DEPTH: depth_code_r <= cfg_data[CODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Gain, pan and handshake terms
  // --------------------------------------------------------------------------
  always_comb begin
    lfo_en    = (phase_step_r != '0) && (depth_code_r != '0);
    gain_val  = GAIN_TAB[gain_code_r];
    if (pan_code_r <= PAN_CENTER) begin
      pan_l = PAN_UNITY;
      pan_r = {pan_code_r, 10'b0};
    end else begin
      pan_l = {CODE_W'(7'd0 - pan_code_r), 10'b0};
      pan_r = PAN_UNITY;
    end
    in_accept = in_valid && !in_stall;
    out_free  = !out_valid_r || !out_stall;
  end

  assign in_stall = (state_r != ST_IDLE) || !rst_n;

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_accept) state_nxt = ST_MG_L;
      ST_MG_L: if (mul_done) state_nxt = ST_MG_R;
      ST_MG_R: if (mul_done) state_nxt = lfo_en ? ST_IDX : ST_ML;
      ST_IDX:  if (mul_done) state_nxt = ST_ROM;
      ST_ROM:  state_nxt = ST_MAG;
      ST_MAG:  if (mul_done) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_ML;
      ST_ML:   if (mul_done) state_nxt = ST_MR;
      ST_MR:   if (mul_done) state_nxt = ST_OL;
      ST_OL:   if (mul_done) state_nxt = ST_OR;
      ST_OR:   if (mul_done) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: operand select and unit starts
  // --------------------------------------------------------------------------
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state_r)
      ST_MG_L: begin
        mul_start = go_r;
        mul_a     = MUL_A_W'(gain_val);
        mul_b     = MUL_B_W'(pan_l);
      end
      ST_MG_R: begin
        mul_start = go_r;
        mul_a     = MUL_A_W'(gain_val);
        mul_b     = MUL_B_W'(pan_r);
      end
      ST_IDX: begin
        mul_start = go_r;
        mul_a     = MUL_A_W'(lfo_phase_r[PHASE_POS_W-1:0]);
        mul_b     = MUL_B_W'(SINE_TABLE_DEPTH);
      end
      ST_MAG: begin
        mul_start = go_r;
        mul_a     = MUL_A_W'(rom_q_r);
        mul_b     = MUL_B_W'(depth_code_r);
      end
      ST_DIV: begin
        div_start = go_r;
      end
      ST_ML: begin
        mul_start = go_r;
        mul_a     = MUL_A_W'(mg_l_r);
        mul_b     = MUL_B_W'(f_l_r);
      end
      ST_MR: begin
        mul_start = go_r;
        mul_a     = MUL_A_W'(mg_r_r);
        mul_b     = MUL_B_W'(f_r_r);
      end
      ST_OL: begin
        mul_start = go_r;
        mul_a     = MUL_A_W'(samp_l_r);
        mul_b     = ml_r;
      end
      ST_OR: begin
        mul_start = go_r;
        mul_a     = MUL_A_W'(samp_r_r);
        mul_b     = mr_r;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Product post-processing: rounding, table index, saturation
  // --------------------------------------------------------------------------
  always_comb begin
    rnd16    = $unsigned(mul_prod) + MUL_P_W'(32768);
    rnd15    = $unsigned(mul_prod) + MUL_P_W'(16384);
    idx_raw  = mul_prod[PHASE_POS_W +: IDX_W];
    idx_c    = (idx_raw > IDX_W'(SINE_TABLE_DEPTH)) ? IDX_W'(SINE_TABLE_DEPTH) : idx_raw;
    rom_addr = lfo_phase_r[PHASE_POS_W] ? IDX_W'(SINE_TABLE_DEPTH) - idx_c : idx_c;
    div_num  = mul_prod[DIV_N_W-1:0] + DIV_N_W'(LFO_DEPTH_RND);
    sat_hi   = rnd16[MUL_P_W-1 -: SAT_HI_W];
    if ((&sat_hi) || !(|sat_hi)) begin
      sat_res = $signed(rnd16[16 +: SAMPLE_BITS]);
    end else begin
      sat_res = $signed({sat_hi[SAT_HI_W-1], {(SAMPLE_BITS-1){~sat_hi[SAT_HI_W-1]}}});
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      lfo_phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      go_r    <= (state_nxt != state_r);
      // hold the result until taken, load a new one when the slot frees
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      // advance the phase once per LFO item
      if (state_r == ST_DIV && div_done) begin
        lfo_phase_r <= lfo_phase_r + PHASE_W'(phase_step_r);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    rom_q_r <= SINE_ROM[rom_addr_r];
    if (in_accept) begin
      samp_l_r <= in_left_sample;
      samp_r_r <= in_right_sample;
    end
    if (mul_done) begin
      unique case (state_r)
        ST_MG_L: mg_l_r <= rnd16[16 +: MG_W];
        ST_MG_R: begin
          mg_r_r <= rnd16[16 +: MG_W];
          f_l_r  <= Q15_ONE;
          f_r_r  <= Q15_ONE;
        end
        ST_IDX:  rom_addr_r <= rom_addr;
        ST_ML:   ml_r <= rnd15[15 +: MULT_W];
        ST_MR:   mr_r <= rnd15[15 +: MULT_W];
        ST_OL:   res_l_r <= sat_res;
        ST_OR:   res_r_r <= sat_res;
        default: begin
        end
      endcase
    end
    // swing the factors around unity, direction set by the half-turn bit
    if (state_r == ST_DIV && div_done) begin
      if (lfo_phase_r[PHASE_W-1]) begin
        f_l_r <= Q15_ONE + FACT_W'(div_quot);
        f_r_r <= Q15_ONE - FACT_W'(div_quot);
      end else begin
        f_l_r <= Q15_ONE - FACT_W'(div_quot);
        f_r_r <= Q15_ONE + FACT_W'(div_quot);
      end
    end
    if (state_r == ST_DONE && out_free) begin
      out_left_r  <= res_l_r;
      out_right_r <= res_r_r;
    end
  end

  // --------------------------------------------------------------------------
  // Shared arithmetic units
  // --------------------------------------------------------------------------
  sglfo_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  sglfo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_phase_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_DIV) |=> $stable(lfo_phase_r))
    else $error("LFO phase moved outside the divide step");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide step");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised without a finished transaction");

  a_mul_idle_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !mul_start)
    else $error("multiplier started during the divide step");

endmodule

`default_nettype wire

### rtl/sglfo_mul.sv
// ----------------------------------------------------------------------------
// sglfo_mul
// Bit-serial multiplier: signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle, full-width product held until next start.
// ----------------------------------------------------------------------------
`default_nettype none

module sglfo_mul
  import sglfo_pkg::*;
#(
  parameter int A_W = 31,
  parameter int B_W = MUL_B_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic signed [A_W-1:0]  a,
  input  wire logic        [B_W-1:0]  b,
  output logic                        done,
  output logic signed [A_W+B_W-1:0]   prod
);

  localparam int CNT_W = $clog2(B_W);

  logic signed [A_W-1:0] a_r;
  logic [B_W-1:0]        b_r;
  logic signed [A_W-1:0] acc_r;
  logic [B_W-1:0]        plo_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic signed [A_W:0]   sum;

  // Add the multiplicand when the current multiplier bit is set
  always_comb begin
    sum = {acc_r[A_W-1], acc_r} + (b_r[0] ? {a_r[A_W-1], a_r} : '0);
  end

  // Control: busy for one cycle per multiplier bit, then pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(B_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the partial product right one bit per cycle
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
      plo_r <= '0;
    end else if (busy_r) begin
      acc_r <= sum[A_W:1];
      plo_r <= {sum[0], plo_r[B_W-1:1]};
      b_r   <= b_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = {acc_r, plo_r};

endmodule

`default_nettype wire

### rtl/sglfo_div.sv
// ----------------------------------------------------------------------------
// sglfo_div
// Restoring divider by the constant depth denominator, one quotient bit
// per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module sglfo_div
  import sglfo_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DIV_N_W-1:0] num,
  output logic                    done,
  output logic [MAG_W-1:0]        quot
);

  localparam int CNT_W = $clog2(DIV_N_W);
  localparam logic [DIV_R_W:0] DEN = (DIV_R_W + 1)'(LFO_DEPTH_DEN);

  logic [DIV_N_W-1:0] num_r;
  logic [MAG_W-1:0]   q_r;
  logic [DIV_R_W-1:0] rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [DIV_R_W:0]   trial;
  logic               ge;

  // Bring down the next numerator bit and compare against the divisor
  always_comb begin
    trial = {rem_r, num_r[DIV_N_W-1]};
    ge    = (trial >= DEN);
  end

  // Control: one cycle per numerator bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift numerator out, quotient bits in (the quotient fits MAG_W)
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      num_r <= num;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= ge ? DIV_R_W'(trial - DEN) : trial[DIV_R_W-1:0];
      q_r   <= {q_r[MAG_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire
